// ===== rtl/tgtr_pkg.sv =====
// Package for the tile id to tile rectangle block.
// Holds field widths, codes, controller states and the controller/datapath structs.
// No dependencies.
package tgtr_pkg;

    // Field widths fixed by the item formats.
    localparam int FUNC_W   = 1;
    localparam int SLOT_W   = 3;
    localparam int GID_W    = 24;
    localparam int COLS_W   = 13;
    localparam int TSIZE_W  = 11;
    localparam int CELL_W   = 20;
    localparam int LAYER_W  = 8;
    localparam int TIDX_W   = 3;
    localparam int DX_W     = 22;
    localparam int DY_W     = 31;
    localparam int SX_W     = 22;
    localparam int SY_W     = 34;
    localparam int MAPW_W   = 13;
    localparam int COUNT_W  = 4;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Reset values of the configuration registers.
    localparam logic [MAPW_W-1:0]  MAP_WIDTH_RST = MAPW_W'(1);
    localparam logic [TSIZE_W-1:0] MAP_TILE_RST  = TSIZE_W'(16);
    localparam logic [COUNT_W-1:0] COUNT_RST     = COUNT_W'(1);

    // Item function codes.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENTRY = 1'b0,
        FUNC_TILE  = 1'b1
    } func_t;

    // Configuration register indexes (byte address / 4).
    typedef enum logic [1:0] {
        REG_MAP_WIDTH       = 2'd0,
        REG_MAP_TILE_WIDTH  = 2'd1,
        REG_MAP_TILE_HEIGHT = 2'd2,
        REG_TILESET_COUNT   = 2'd3
    } cfg_reg_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL,
        ST_FIN
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic scan_step;
        logic load;
        logic div_start;
        logic mul;
        logic fin;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_tile;
        logic scan_done;
        logic div_busy;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== rtl/tgtr_in_if.sv =====
// Input channel interface: valid/ready handshake with the input item fields.
// Depends on tgtr_pkg.
interface tgtr_in_if;
    import tgtr_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [SLOT_W-1:0]  tileset_slot;
    logic [GID_W-1:0]   entry_first_gid;
    logic [COLS_W-1:0]  entry_columns;
    logic [TSIZE_W-1:0] entry_tile_width;
    logic [TSIZE_W-1:0] entry_tile_height;
    logic               entry_image_collection;
    logic [GID_W-1:0]   tile_id;
    logic [CELL_W-1:0]  cell_index;
    logic [LAYER_W-1:0] layer_number;
    logic               solid;

    modport source (
        output valid, func, tileset_slot, entry_first_gid, entry_columns,
               entry_tile_width, entry_tile_height, entry_image_collection,
               tile_id, cell_index, layer_number, solid,
        input  ready
    );

    modport sink (
        input  valid, func, tileset_slot, entry_first_gid, entry_columns,
               entry_tile_width, entry_tile_height, entry_image_collection,
               tile_id, cell_index, layer_number, solid,
        output ready
    );
endinterface

// ===== rtl/tgtr_out_if.sv =====
// Output channel interface: valid/ready handshake with the result item fields.
// Depends on tgtr_pkg.
interface tgtr_out_if;
    import tgtr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [TIDX_W-1:0]        tileset_index;
    logic [DX_W-1:0]          dst_x;
    logic signed [DY_W-1:0]   dst_y;
    logic [TSIZE_W-1:0]       dst_w;
    logic [TSIZE_W-1:0]       dst_h;
    logic [SX_W-1:0]          src_x;
    logic [SY_W-1:0]          src_y;
    logic [TSIZE_W-1:0]       src_w;
    logic [TSIZE_W-1:0]       src_h;
    logic [LAYER_W-1:0]       layer_out;
    logic                     solid_out;
    logic                     bad_gid;

    modport source (
        output valid, tileset_index, dst_x, dst_y, dst_w, dst_h, src_x, src_y,
               src_w, src_h, layer_out, solid_out, bad_gid,
        input  ready
    );

    modport sink (
        input  valid, tileset_index, dst_x, dst_y, dst_w, dst_h, src_x, src_y,
               src_w, src_h, layer_out, solid_out, bad_gid,
        output ready
    );
endinterface

// ===== rtl/tilemap_gid_to_tile_rects_core.sv =====
// Top level of the tile id to tile rectangle block: configuration registers,
// controller and datapath. Depends on tgtr_pkg, the channel interfaces, tgtr_ctrl and tgtr_dp.
//
// Entry items (func 0) and blank tiles (id 0) are taken in the idle state and give no result.
// A placed tile walks the table entries, one per cycle, up to the active tileset count to
// find its tileset; the bulk of its work is the 24-step bit-serial divider on the tile id
// offset, which runs alongside the 20-step divider on the cell index. A new item is
// taken the cycle after the result enters the output register, even while that result
// still waits for its transfer. The user must write configuration through the APB port
// only while the block is idle; the block itself does not enforce this. The table resets
// to all zero.
module tilemap_gid_to_tile_rects_core #(
    parameter int MAX_TILESETS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    tgtr_in_if.sink                           tile_in,
    tgtr_out_if.source                        rect_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tgtr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tgtr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tgtr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import tgtr_pkg::*;

    logic [MAPW_W-1:0]  map_width_reg;
    logic [TSIZE_W-1:0] map_tile_width_reg;
    logic [TSIZE_W-1:0] map_tile_height_reg;
    logic [COUNT_W-1:0] tileset_count_reg;

    cfg_reg_t           reg_sel;
    logic               cfg_write;
    ctrl_cmd_t          cmd;
    ctrl_status_t       status;

    assign pready    = 1'b1;
    assign reg_sel   = cfg_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg       <= MAP_WIDTH_RST;
            map_tile_width_reg  <= MAP_TILE_RST;
            map_tile_height_reg <= MAP_TILE_RST;
            tileset_count_reg   <= COUNT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_MAP_WIDTH:       map_width_reg       <= pwdata[MAPW_W-1:0];
                REG_MAP_TILE_WIDTH:  map_tile_width_reg  <= pwdata[TSIZE_W-1:0];
                REG_MAP_TILE_HEIGHT: map_tile_height_reg <= pwdata[TSIZE_W-1:0];
                REG_TILESET_COUNT:   tileset_count_reg   <= pwdata[COUNT_W-1:0];
                default:             map_width_reg       <= map_width_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_sel)
            REG_MAP_WIDTH:       prdata = APB_DATA_W'(map_width_reg);
            REG_MAP_TILE_WIDTH:  prdata = APB_DATA_W'(map_tile_width_reg);
            REG_MAP_TILE_HEIGHT: prdata = APB_DATA_W'(map_tile_height_reg);
            REG_TILESET_COUNT:   prdata = APB_DATA_W'(tileset_count_reg);
            default:             prdata = '0;
        endcase
    end

    // Controller.
    tgtr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // Datapath.
    tgtr_dp #(
        .MAX_TILESETS (MAX_TILESETS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .tile_in         (tile_in),
        .rect_out        (rect_out),
        .map_width       (map_width_reg),
        .map_tile_width  (map_tile_width_reg),
        .map_tile_height (map_tile_height_reg),
        .tileset_count   (tileset_count_reg),
        .cmd             (cmd),
        .status          (status)
    );

    // A new result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!rect_out.valid || rect_out.ready))
        else $error("result register overwritten before transfer");

    // A placed tile closes the input until its result is loaded.
    a_busy_after_tile: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.in_ready && status.start_tile) |=> !cmd.in_ready)
        else $error("input open while a tile is in progress");

    // A result only appears after the controller loads it.
    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rect_out.valid) |-> $past(cmd.fin))
        else $error("result valid without a load");

    // The products are only taken once both dividers have finished.
    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |-> !status.div_busy)
        else $error("multiply while a division is running");

endmodule

// ===== rtl/tgtr_div.sv =====
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Stand-alone; no package dependency.
module tgtr_div #(
    parameter int DIVIDEND_W = 24,
    parameter int DIVISOR_W  = 13
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic                  fits;
    logic [DIVISOR_W:0]    rem_diff;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_diff  = rem_shift - {1'b0, div_reg};
    end

    // Step counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIVIDEND_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/tgtr_ctrl.sv =====
// Controller state machine: sequences scan, entry load, division, multiply
// and result hand-off. Depends on tgtr_pkg.
module tgtr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgtr_pkg::ctrl_status_t status,
    output tgtr_pkg::ctrl_cmd_t    cmd
);
    import tgtr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.start_tile)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:      state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:       state_next = ST_FIN;
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:      cmd.in_ready  = 1'b1;
            ST_SCAN:      cmd.scan_step = 1'b1;
            ST_LOAD:      cmd.load      = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd           = '0;
            ST_MUL:       cmd.mul       = 1'b1;
            ST_FIN:       cmd.fin       = status.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule

// ===== rtl/tgtr_dp.sv =====
// Datapath: tileset table, id scan, entry registers, two serial dividers,
// products and the output register. Depends on tgtr_pkg, tgtr_div and the channel interfaces.
module tgtr_dp #(
    parameter int MAX_TILESETS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tgtr_in_if.sink                        tile_in,
    tgtr_out_if.source                     rect_out,
    input  logic [tgtr_pkg::MAPW_W-1:0]    map_width,
    input  logic [tgtr_pkg::TSIZE_W-1:0]   map_tile_width,
    input  logic [tgtr_pkg::TSIZE_W-1:0]   map_tile_height,
    input  logic [tgtr_pkg::COUNT_W-1:0]   tileset_count,
    input  tgtr_pkg::ctrl_cmd_t            cmd,
    output tgtr_pkg::ctrl_status_t         status
);
    import tgtr_pkg::*;

    localparam int IDX_W = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;

    // Tileset table.
    logic [GID_W-1:0]   first_gid_reg [MAX_TILESETS];
    logic [COLS_W-1:0]  columns_reg   [MAX_TILESETS];
    logic [TSIZE_W-1:0] tile_w_reg    [MAX_TILESETS];
    logic [TSIZE_W-1:0] tile_h_reg    [MAX_TILESETS];
    logic               coll_reg      [MAX_TILESETS];

    // Captured tile item.
    logic [GID_W-1:0]   gid_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [LAYER_W-1:0] layer_reg;
    logic               solid_reg;

    // Scan state.
    logic [IDX_W-1:0]   idx_reg;
    logic               prev_ge_reg;
    logic [IDX_W-1:0]   sel_reg;
    logic [IDX_W-1:0]   last_idx;

    // Selected entry.
    logic [GID_W-1:0]   n_reg;
    logic               bad_reg;
    logic [COLS_W-1:0]  ent_cols_reg;
    logic [TSIZE_W-1:0] ent_tw_reg;
    logic [TSIZE_W-1:0] ent_th_reg;
    logic               ent_coll_reg;

    // Products.
    logic [DX_W-1:0]    dx_reg;
    logic [DY_W-1:0]    dy_reg;
    logic [SX_W-1:0]    sx_reg;
    logic [SY_W-1:0]    sy_reg;

    // Output register.
    logic               out_valid_reg;
    logic [TIDX_W-1:0]  o_tidx_reg;
    logic [DX_W-1:0]    o_dx_reg;
    logic [DY_W-1:0]    o_dy_reg;
    logic [TSIZE_W-1:0] o_dw_reg;
    logic [TSIZE_W-1:0] o_dh_reg;
    logic [SX_W-1:0]    o_sx_reg;
    logic [SY_W-1:0]    o_sy_reg;
    logic [TSIZE_W-1:0] o_sw_reg;
    logic [TSIZE_W-1:0] o_sh_reg;
    logic [LAYER_W-1:0] o_layer_reg;
    logic               o_solid_reg;
    logic               o_bad_reg;

    logic               accept;
    logic [IDX_W-1:0]   rd_idx;
    logic [GID_W-1:0]   rd_first;
    logic               cur_ge;
    logic               pair_hit;
    logic               at_last;
    logic [MAPW_W-1:0]  map_w_eff;
    logic [COLS_W-1:0]  rd_cols_eff;
    logic               div_c_busy;
    logic               div_n_busy;
    logic [CELL_W-1:0]  quo_c;
    logic [MAPW_W-1:0]  rem_c;
    logic [GID_W-1:0]   quo_n;
    logic [COLS_W-1:0]  rem_n;
    logic [23:0]        dx_full;
    logic [DY_W-1:0]    dy_full;
    logic [23:0]        sx_full;
    logic [34:0]        sy_full;
    logic [DY_W-1:0]    dy_adj;

    assign accept       = tile_in.valid && cmd.in_ready;
    assign tile_in.ready = cmd.in_ready;

    // Last entry index in use, with a zero count taken as one.
    always_comb
    begin
        if (tileset_count == '0)
        begin
            last_idx = '0;
        end
        else if (int'(tileset_count) > MAX_TILESETS)
        begin
            last_idx = IDX_W'(MAX_TILESETS - 1);
        end
        else
        begin
            last_idx = IDX_W'(int'(tileset_count) - 1);
        end
    end

    // Table write from entry items; slots past the table are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_TILESETS; k++)
            begin
                first_gid_reg[k] <= '0;
                columns_reg[k]   <= '0;
                tile_w_reg[k]    <= '0;
                tile_h_reg[k]    <= '0;
                coll_reg[k]      <= 1'b0;
            end
        end
        else if (accept && tile_in.func == FUNC_ENTRY)
        begin
            for (int k = 0; k < MAX_TILESETS; k++)
            begin
                if (int'(tile_in.tileset_slot) == k)
                begin
                    first_gid_reg[k] <= tile_in.entry_first_gid;
                    columns_reg[k]   <= tile_in.entry_columns;
                    tile_w_reg[k]    <= tile_in.entry_tile_width;
                    tile_h_reg[k]    <= tile_in.entry_tile_height;
                    coll_reg[k]      <= tile_in.entry_image_collection;
                end
            end
        end
    end

    // Single table read port: the scan index, or the chosen entry during load.
    always_comb
    begin
        rd_idx      = cmd.load ? sel_reg : idx_reg;
        rd_first    = first_gid_reg[rd_idx];
        rd_cols_eff = (columns_reg[rd_idx] == '0) ? COLS_W'(1) : columns_reg[rd_idx];
        map_w_eff   = (map_width == '0) ? MAPW_W'(1) : map_width;
    end

    // Scan decision: the previous entry owns the id when it lies in its span.
    always_comb
    begin
        cur_ge   = gid_reg >= rd_first;
        pair_hit = (idx_reg != '0) && prev_ge_reg && !cur_ge;
        at_last  = idx_reg == last_idx;
    end

    // Scan index, capture of the tile item.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gid_reg   <= tile_in.tile_id;
            cell_reg  <= tile_in.cell_index;
            layer_reg <= tile_in.layer_number;
            solid_reg <= tile_in.solid;
            idx_reg   <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (pair_hit)
            begin
                sel_reg <= idx_reg - IDX_W'(1);
            end
            else if (at_last)
            begin
                sel_reg <= idx_reg;
            end
            else
            begin
                idx_reg     <= idx_reg + IDX_W'(1);
                prev_ge_reg <= cur_ge;
            end
        end
    end

    // Load the chosen entry and the id offset within it.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg        <= gid_reg - rd_first;
            bad_reg      <= !cur_ge;
            ent_cols_reg <= rd_cols_eff;
            ent_tw_reg   <= tile_w_reg[rd_idx];
            ent_th_reg   <= tile_h_reg[rd_idx];
            ent_coll_reg <= coll_reg[rd_idx];
        end
    end

    // Cell index over map width.
    tgtr_div #(
        .DIVIDEND_W (CELL_W),
        .DIVISOR_W  (MAPW_W)
    ) u_div_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (cell_reg),
        .divisor   (map_w_eff),
        .busy      (div_c_busy),
        .quotient  (quo_c),
        .remainder (rem_c)
    );

    // Id offset over tileset columns.
    tgtr_div #(
        .DIVIDEND_W (GID_W),
        .DIVISOR_W  (COLS_W)
    ) u_div_gid (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (ent_cols_reg),
        .busy      (div_n_busy),
        .quotient  (quo_n),
        .remainder (rem_n)
    );

    // Pixel products, each a single narrow multiply.
    always_comb
    begin
        dx_full = 24'(rem_c) * 24'(map_tile_width);
        dy_full = DY_W'(quo_c) * DY_W'(map_tile_height);
        sx_full = 24'(rem_n) * 24'(ent_tw_reg);
        sy_full = 35'(quo_n) * 35'(ent_th_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            dx_reg <= dx_full[DX_W-1:0];
            dy_reg <= dy_full;
            sx_reg <= sx_full[SX_W-1:0];
            sy_reg <= sy_full[SY_W-1:0];
        end
    end

    // Image-collection tiles sit higher by the tile height difference.
    always_comb
    begin
        if (ent_coll_reg)
        begin
            dy_adj = dy_reg + DY_W'(map_tile_height) - DY_W'(ent_th_reg);
        end
        else
        begin
            dy_adj = dy_reg;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rect_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            o_tidx_reg  <= TIDX_W'(sel_reg);
            o_dx_reg    <= dx_reg;
            o_dy_reg    <= dy_adj;
            o_dw_reg    <= map_tile_width;
            o_dh_reg    <= map_tile_height;
            o_sx_reg    <= bad_reg ? '0 : sx_reg;
            o_sy_reg    <= bad_reg ? '0 : sy_reg;
            o_sw_reg    <= ent_tw_reg;
            o_sh_reg    <= ent_th_reg;
            o_layer_reg <= layer_reg;
            o_solid_reg <= solid_reg;
            o_bad_reg   <= bad_reg;
        end
    end

    assign rect_out.valid         = out_valid_reg;
    assign rect_out.tileset_index = o_tidx_reg;
    assign rect_out.dst_x         = o_dx_reg;
    assign rect_out.dst_y         = o_dy_reg;
    assign rect_out.dst_w         = o_dw_reg;
    assign rect_out.dst_h         = o_dh_reg;
    assign rect_out.src_x         = o_sx_reg;
    assign rect_out.src_y         = o_sy_reg;
    assign rect_out.src_w         = o_sw_reg;
    assign rect_out.src_h         = o_sh_reg;
    assign rect_out.layer_out     = o_layer_reg;
    assign rect_out.solid_out     = o_solid_reg;
    assign rect_out.bad_gid       = o_bad_reg;

    // Status back to the controller.
    always_comb
    begin
        status.start_tile = tile_in.valid && tile_in.func == FUNC_TILE
                            && tile_in.tile_id != '0;
        status.scan_done  = pair_hit || at_last;
        status.div_busy   = div_c_busy || div_n_busy;
        status.out_free   = !out_valid_reg || rect_out.ready;
    end

endmodule
